// File: hw/rtl/soce_pkg.sv
package soce_pkg;

	localparam int MAX_TRACKS = 256;
	localparam int IDX_W = 8;
	localparam int CNT_W = 9;

	localparam logic [63:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX_MUL_A = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_MUL_B = 64'h94D049BB133111EB;

	localparam logic [2:0] OP_LOAD = 3'd0;
	localparam logic [2:0] OP_SET_SHUFFLE = 3'd1;
	localparam logic [2:0] OP_RESHUFFLE = 3'd2;
	localparam logic [2:0] OP_NEXT = 3'd3;
	localparam logic [2:0] OP_PREV = 3'd4;
	localparam logic [2:0] OP_SELECT = 3'd5;
	localparam logic [2:0] OP_CLEAR = 3'd6;
	localparam logic [2:0] OP_QUERY = 3'd7;

	typedef struct packed {
		logic [2:0] opcode;
		logic loop_around;
		logic shuffle_flag;
		logic [CNT_W-1:0] track_count;
		logic keep_valid;
		logic [IDX_W-1:0] keep_track;
		logic [IDX_W-1:0] select_index;
	} req_t;

	typedef struct packed {
		logic ok;
		logic is_empty;
		logic [IDX_W-1:0] cursor;
		logic [IDX_W-1:0] current_track;
		logic [CNT_W-1:0] count_now;
		logic shuffle_now;
	} rsp_t;

	typedef struct packed {
		logic start;
		logic [CNT_W-1:0] divisor;
	} rng_req_t;

	typedef struct packed {
		logic done;
		logic [IDX_W-1:0] pick;
	} rng_rsp_t;

endpackage

// File: hw/rtl/shuffled_order_cursor_engine.sv
// channel | signals                          | direction
// req     | req_valid, req_stall, req        | in  (one operation)
// rsp     | rsp_valid, rsp_stall, rsp        | out (one result per operation)
// cfg     | cfg_valid, cfg_ready, cfg_data   | in  (generator seed)
// Simple opcodes pass through S_ORD, S_OWAIT and S_FIN; the result is registered in S_FIN
// and the next request is taken in S_IDLE. A rebuild first fetches the kept entry (set shuffle,
// reshuffle), writes N fill entries, does N-1 swaps in shuffle mode (each a multiply, a
// remainder and sequencing) and then searches up to N entries for the kept track.
// Reset clears count, cursor, shuffle mode and generator state; table content is unset.
// req is stalled while an operation is in progress; a held result lets one more request in,
// which then waits in its last cycle until the result is taken.
module shuffled_order_cursor_engine (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input soce_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output soce_pkg::rsp_t rsp,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [63:0] cfg_data
);
	import soce_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_KRD = 4'd1;
	localparam logic [3:0] S_KWAIT = 4'd2;
	localparam logic [3:0] S_FILL = 4'd3;
	localparam logic [3:0] S_SW_START = 4'd4;
	localparam logic [3:0] S_SW_WAIT = 4'd5;
	localparam logic [3:0] S_SW_RDA = 4'd6;
	localparam logic [3:0] S_SW_RDB = 4'd7;
	localparam logic [3:0] S_SW_WA = 4'd8;
	localparam logic [3:0] S_SW_WB = 4'd9;
	localparam logic [3:0] S_SRCH_RD = 4'd10;
	localparam logic [3:0] S_SRCH_CMP = 4'd11;
	localparam logic [3:0] S_ORD = 4'd12;
	localparam logic [3:0] S_OWAIT = 4'd13;
	localparam logic [3:0] S_FIN = 4'd14;

	logic [3:0] state_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] cursor_q;
	logic mode_q;
	logic ok_q;
	logic have_q;
	logic [IDX_W-1:0] keep_q;
	logic [CNT_W-1:0] idx_q;
	logic [IDX_W-1:0] pick_q;
	logic [IDX_W-1:0] ta_q;
	logic [IDX_W-1:0] trk_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic accept;
	logic [CNT_W-1:0] load_cnt;
	logic mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [IDX_W-1:0] mem_wdata;
	logic [IDX_W-1:0] mem_raddr;
	logic [IDX_W-1:0] mem_rdata;
	logic [IDX_W-1:0] last_ix;
	rng_req_t rng_req;
	rng_rsp_t rng_rsp;

	assign accept = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
	assign last_ix = idx_q[IDX_W-1:0] - 8'd1;
	assign load_cnt = (req.track_count > CNT_W'(MAX_TRACKS)) ? CNT_W'(MAX_TRACKS)
		: req.track_count;

	assign rng_req.start = (state_q == S_SW_START);
	assign rng_req.divisor = idx_q;

	soce_rng u_rng (
		.clk(clk),
		.arst_n(arst_n),
		.seed_we(cfg_valid),
		.seed(cfg_data),
		.req(rng_req),
		.rsp(rng_rsp)
	);

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = idx_q[IDX_W-1:0];
		mem_wdata = idx_q[IDX_W-1:0];
		mem_raddr = cursor_q;
		case (state_q)
			S_FILL: mem_we = 1'b1;
			S_SW_RDA: mem_raddr = last_ix;
			S_SW_RDB: mem_raddr = pick_q;
			S_SW_WA: begin
				mem_we = 1'b1;
				mem_waddr = last_ix;
				mem_wdata = mem_rdata;
			end
			S_SW_WB: begin
				mem_we = 1'b1;
				mem_waddr = pick_q;
				mem_wdata = ta_q;
			end
			S_SRCH_RD: mem_raddr = idx_q[IDX_W-1:0];
			default: ;
		endcase
	end

	soce_mem u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			cursor_q <= '0;
			mode_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.opcode)
							OP_LOAD: begin
								ok_q <= 1'b1;
								count_q <= load_cnt;
								have_q <= req.keep_valid;
								keep_q <= req.keep_track;
								cursor_q <= '0;
								idx_q <= '0;
								state_q <= (load_cnt == '0) ? S_ORD : S_FILL;
							end
							OP_SET_SHUFFLE: begin
								ok_q <= 1'b1;
								if (req.shuffle_flag != mode_q) begin
									mode_q <= req.shuffle_flag;
									state_q <= S_KRD;
								end else begin
									state_q <= S_ORD;
								end
							end
							OP_RESHUFFLE: begin
								if (mode_q) begin
									ok_q <= 1'b1;
									state_q <= S_KRD;
								end else begin
									ok_q <= 1'b0;
									state_q <= S_ORD;
								end
							end
							OP_NEXT: begin
								state_q <= S_ORD;
								if (count_q == '0) begin
									ok_q <= 1'b0;
								end else if ({1'b0, cursor_q} + 9'd1 < count_q) begin
									ok_q <= 1'b1;
									cursor_q <= cursor_q + 8'd1;
								end else if (req.loop_around) begin
									ok_q <= 1'b1;
									cursor_q <= '0;
								end else begin
									ok_q <= 1'b0;
								end
							end
							OP_PREV: begin
								state_q <= S_ORD;
								if (count_q == '0) begin
									ok_q <= 1'b0;
								end else if (cursor_q != '0) begin
									ok_q <= 1'b1;
									cursor_q <= cursor_q - 8'd1;
								end else if (req.loop_around) begin
									ok_q <= 1'b1;
									cursor_q <= count_q[IDX_W-1:0] - 8'd1;
								end else begin
									ok_q <= 1'b0;
								end
							end
							OP_SELECT: begin
								state_q <= S_ORD;
								if ({1'b0, req.select_index} < count_q) begin
									ok_q <= 1'b1;
									cursor_q <= req.select_index;
								end else begin
									ok_q <= 1'b0;
								end
							end
							OP_CLEAR: begin
								ok_q <= 1'b1;
								state_q <= S_ORD;
								count_q <= '0;
								cursor_q <= '0;
							end
							default: begin
								ok_q <= 1'b1;
								state_q <= S_ORD;
							end
						endcase
					end
				end
				S_KRD: begin
					have_q <= (count_q != '0);
					state_q <= S_KWAIT;
				end
				S_KWAIT: begin
					keep_q <= mem_rdata;
					cursor_q <= '0;
					idx_q <= '0;
					state_q <= (count_q == '0) ? S_ORD : S_FILL;
				end
				S_FILL: begin
					if (idx_q + 9'd1 == count_q) begin
						if (mode_q && count_q > 9'd1) begin
							idx_q <= count_q;
							state_q <= S_SW_START;
						end else begin
							idx_q <= '0;
							state_q <= have_q ? S_SRCH_RD : S_ORD;
						end
					end else begin
						idx_q <= idx_q + 9'd1;
					end
				end
				S_SW_START: state_q <= S_SW_WAIT;
				S_SW_WAIT: begin
					if (rng_rsp.done) begin
						pick_q <= rng_rsp.pick;
						state_q <= S_SW_RDA;
					end
				end
				S_SW_RDA: state_q <= S_SW_RDB;
				S_SW_RDB: begin
					ta_q <= mem_rdata;
					state_q <= S_SW_WA;
				end
				S_SW_WA: state_q <= S_SW_WB;
				S_SW_WB: begin
					if (idx_q == 9'd2) begin
						idx_q <= '0;
						state_q <= have_q ? S_SRCH_RD : S_ORD;
					end else begin
						idx_q <= idx_q - 9'd1;
						state_q <= S_SW_START;
					end
				end
				S_SRCH_RD: state_q <= S_SRCH_CMP;
				S_SRCH_CMP: begin
					if (mem_rdata == keep_q) begin
						cursor_q <= idx_q[IDX_W-1:0];
						state_q <= S_ORD;
					end else if (idx_q + 9'd1 == count_q) begin
						state_q <= S_ORD;
					end else begin
						idx_q <= idx_q + 9'd1;
						state_q <= S_SRCH_RD;
					end
				end
				S_ORD: state_q <= S_OWAIT;
				S_OWAIT: begin
					trk_q <= mem_rdata;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q.ok <= ok_q;
			rsp_q.is_empty <= (count_q == '0);
			rsp_q.cursor <= (count_q == '0) ? '0 : cursor_q;
			rsp_q.current_track <= (count_q == '0) ? '0 : trk_q;
			rsp_q.count_now <= count_q;
			rsp_q.shuffle_now <= mode_q;
		end
	end

`ifndef ASSERT_OFF
	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && count_q != '0) |-> ({1'b0, cursor_q} < count_q))
		else $error("cursor beyond entry count");
	a_cursor_zero_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && count_q == '0) |-> (cursor_q == '0))
		else $error("cursor not zero on empty order");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_TRACKS))
		else $error("entry count above maximum");
	a_draw_expected: assert property (@(posedge clk) disable iff (!arst_n)
		rng_rsp.done |-> (state_q == S_SW_WAIT))
		else $error("random draw finished outside swap wait");
`endif

endmodule

// File: hw/rtl/soce_mem.sv
module soce_mem (
	input logic clk,
	input logic we,
	input logic [soce_pkg::IDX_W-1:0] waddr,
	input logic [soce_pkg::IDX_W-1:0] wdata,
	input logic [soce_pkg::IDX_W-1:0] raddr,
	output logic [soce_pkg::IDX_W-1:0] rdata
);
	import soce_pkg::*;

	logic [IDX_W-1:0] mem [MAX_TRACKS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/soce_rng.sv
module soce_rng (
	input logic clk,
	input logic arst_n,
	input logic seed_we,
	input logic [63:0] seed,
	input soce_pkg::rng_req_t req,
	output soce_pkg::rng_rsp_t rsp
);
	import soce_pkg::*;

	localparam logic [1:0] R_IDLE = 2'd0;
	localparam logic [1:0] R_MUL = 2'd1;
	localparam logic [1:0] R_MOD = 2'd2;

	logic [1:0] st_q;
	logic [63:0] gen_q;
	logic [63:0] z_q;
	logic [63:0] acc_q;
	logic [63:0] prod_q;
	logic [1:0] k_q;
	logic pass_q;
	logic [5:0] bit_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] div_q;
	logic done_q;

	logic [63:0] gen_nx;
	logic [63:0] mul_b;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] mul_p;
	logic [63:0] fin;
	logic [CNT_W-1:0] r2;

	always_comb begin
		gen_nx = gen_q + GOLDEN_GAMMA;
		mul_b = pass_q ? MIX_MUL_B : MIX_MUL_A;
		case (k_q)
			2'd0: begin
				op_a = z_q[31:0];
				op_b = mul_b[31:0];
			end
			2'd1: begin
				op_a = z_q[31:0];
				op_b = mul_b[63:32];
			end
			default: begin
				op_a = z_q[63:32];
				op_b = mul_b[31:0];
			end
		endcase
		mul_p = {32'd0, op_a} * {32'd0, op_b};
		fin = {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
		r2 = {rem_q[IDX_W-1:0], z_q[63]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= R_IDLE;
			gen_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (st_q == R_MOD) && (bit_q == 6'd63);
			case (st_q)
				R_IDLE: begin
					if (seed_we) begin
						gen_q <= seed;
					end else if (req.start) begin
						gen_q <= gen_nx;
						st_q <= R_MUL;
					end
				end
				R_MUL: begin
					if (k_q == 2'd3) begin
						if (pass_q) begin
							st_q <= R_MOD;
						end
					end
				end
				R_MOD: begin
					if (bit_q == 6'd63) begin
						st_q <= R_IDLE;
					end
				end
				default: st_q <= R_IDLE;
			endcase
		end
	end

	// low 64 bits of the product from three partial products, one per cycle
	always_ff @(posedge clk) begin
		case (st_q)
			R_IDLE: begin
				z_q <= gen_nx ^ (gen_nx >> 30);
				div_q <= req.divisor;
				k_q <= 2'd0;
				pass_q <= 1'b0;
			end
			R_MUL: begin
				prod_q <= mul_p;
				k_q <= k_q + 2'd1;
				if (k_q == 2'd1) begin
					acc_q <= prod_q;
				end else if (k_q == 2'd2) begin
					acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
				end else if (k_q == 2'd3) begin
					if (pass_q) begin
						z_q <= fin ^ (fin >> 31);
						bit_q <= '0;
						rem_q <= '0;
					end else begin
						z_q <= fin ^ (fin >> 27);
						pass_q <= 1'b1;
					end
				end
			end
			R_MOD: begin
				z_q <= z_q << 1;
				bit_q <= bit_q + 6'd1;
				rem_q <= (r2 >= div_q) ? r2 - div_q : r2;
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.pick = rem_q[IDX_W-1:0];

endmodule
